>>> rtl/sequence_store_deque_search_macros.svh
// Assertion macros used by the sequence store top level.
`ifndef SEQUENCE_STORE_DEQUE_SEARCH_MACROS_SVH
`define SEQUENCE_STORE_DEQUE_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequence store check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence store check failed");

`endif

>>> rtl/ssds_pkg.sv
// Package with field widths, request codes and status codes of the sequence store.
package ssds_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [ACTION_W-1:0] ACT_APPEND    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK  = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_MATCH = 2'd3;

endpackage

>>> rtl/ssds_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ssds_ram
    import ssds_pkg::*;
#(
    parameter int WIDTH = VALUE_W,
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/sequence_store_deque_search.sv
// Top level of the sequence store: a bounded deque of 32-bit values with search and delete.
//
// The store keeps up to DEPTH signed 32-bit values in append order inside one
// RAM used as a ring (a head pointer marks the front, so popping the front
// moves no data). One request is worked on at a time; the next request is
// taken as soon as the current one has been handed to the output register,
// even if that result still waits for out_ready. Append and unused codes go
// from the start step to the finish step; pops read the entry in the start
// step and take it in the pop-read step; search walks from the front to the
// first match or the back entry, and delete walks to the match and then
// shifts the entries behind it down; the walk and the shift each move one
// entry per cycle through the single read port of the RAM. The RAM needs no
// clearing after reset: only positions below the count are ever read.
`include "sequence_store_deque_search_macros.svh"

module sequence_store_deque_search
    import ssds_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ACTION_W-1:0]        action,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  taken_value,
    output logic [COUNT_W-1:0]         count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_S = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SHIFT,
        S_POP_READ,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [ACTION_W-1:0]    act_reg, act_next;
    logic [VALUE_W-1:0]     val_reg, val_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       occ_reg, occ_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [VALUE_W-1:0]     res_taken_reg, res_taken_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [VALUE_W-1:0]     taken_reg, taken_next;
    logic [COUNT_W-1:0]     count_reg, count_next;

    // RAM port signals
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [VALUE_W-1:0] rd_data;

    logic               full;
    logic               empty;
    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W-1:0]   idx_p1;
    logic [IDX_W-1:0]   idx_p2;
    logic               out_free;

    // Map a position counted from the front onto a RAM address.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[IDX_W-1:0];
    endfunction

    ssds_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign full     = (occ_reg == DEPTH_C);
    assign empty    = (occ_reg == '0);
    // Position of the back entry; only used while the store holds something.
    assign last_idx = IDX_W'(occ_reg - CNT_W'(1));
    assign idx_p1   = idx_reg + IDX_W'(1);
    assign idx_p2   = idx_reg + IDX_W'(2);
    // The output register can take a result when it is empty or is being drained.
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign taken_value = taken_reg;
    assign count       = count_reg;

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        val_next        = val_reg;
        head_next       = head_reg;
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_taken_next  = res_taken_reg;
        status_next     = status_reg;
        taken_next      = taken_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = val_reg;
        rd_en   = 1'b0;
        rd_addr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Latch the request; the previous result may still sit at the output.
                if (in_valid)
                begin
                    act_next   = action;
                    val_next   = value;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                res_status_next = STAT_OK;
                res_taken_next  = '0;
                state_next      = S_FINISH;
                unique case (act_reg)
                    ACT_APPEND:
                    begin
                        if (full)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = phys(head_reg, IDX_W'(occ_reg));
                            wr_data  = val_reg;
                            occ_next = occ_reg + CNT_W'(1);
                        end
                    end
                    ACT_DELETE, ACT_SEARCH:
                    begin
                        if (empty)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            // Start the walk at the front entry.
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    ACT_POP_FRONT, ACT_POP_BACK:
                    begin
                        if (empty)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = (act_reg == ACT_POP_FRONT) ? head_reg
                                                                    : phys(head_reg, last_idx);
                            state_next = S_POP_READ;
                        end
                    end
                    default:
                    begin
                        // Unused codes leave the store alone and report ok.
                    end
                endcase
            end

            S_SCAN:
            begin
                // rd_data holds the entry at position idx_reg.
                if (rd_data == val_reg)
                begin
                    res_status_next = STAT_OK;
                    if (act_reg == ACT_DELETE)
                    begin
                        res_taken_next = val_reg;
                        if (idx_reg == last_idx)
                        begin
                            occ_next   = occ_reg - CNT_W'(1);
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            // Fetch the successor; idx_reg stays as the slot to fill.
                            rd_en      = 1'b1;
                            rd_addr    = phys(head_reg, idx_p1);
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (idx_reg == last_idx)
                begin
                    res_status_next = STAT_NO_MATCH;
                    state_next      = S_FINISH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = phys(head_reg, idx_p1);
                    idx_next = idx_p1;
                end
            end

            S_SHIFT:
            begin
                // Move the entry at idx_reg + 1 down into idx_reg.
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, idx_reg);
                wr_data = rd_data;
                if (idx_p1 == last_idx)
                begin
                    occ_next   = occ_reg - CNT_W'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = phys(head_reg, idx_p2);
                    idx_next = idx_p1;
                end
            end

            S_POP_READ:
            begin
                res_status_next = STAT_OK;
                res_taken_next  = rd_data;
                occ_next        = occ_reg - CNT_W'(1);
                if (act_reg == ACT_POP_FRONT)
                begin
                    head_next = phys(head_reg, IDX_W'(1));
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // Hold the result until the output register is free.
                if (out_free)
                begin
                    status_next    = res_status_reg;
                    taken_next     = res_taken_reg;
                    count_next     = COUNT_W'(occ_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_taken_reg  <= res_taken_next;
        status_reg     <= status_next;
        taken_reg      <= taken_next;
        count_reg      <= count_next;
    end

    // The count never runs past the capacity of the RAM.
    `SSDS_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= DEPTH_C)

    // The walk and the shift stay inside the stored entries.
    `SSDS_ASSERT_IMP(a_idx_bound, clk, rst_n,
        (state_reg == S_SCAN) || (state_reg == S_SHIFT), CNT_W'(idx_reg) < occ_reg)

    // A successful append grows the store by exactly one.
    `SSDS_ASSERT_NEXT(a_append_grow, clk, rst_n,
        (state_reg == S_START) && (act_reg == ACT_APPEND) && !full,
        occ_reg == $past(occ_reg) + CNT_W'(1))

    // A new result only enters the output register from the finish step.
    `SSDS_ASSERT_IMP(a_out_source, clk, rst_n,
        $rose(out_valid_reg), $past(state_reg) == S_FINISH)

endmodule
